@@ hdl/assert_macros.svh @@
// assertion macros shared by the presence table modules
// expects clk and rst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge, off while reset is held
`define NPT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication checked from the edge after the trigger, off while reset is held
`define NPT_ASSERT_NEXT(lbl, trig, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) else $error(msg);

`endif

@@ hdl/npt_pkg.sv @@
// shared types and constants of the node presence table
// no dependencies
`default_nettype none

package npt_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int SLOT_W  = 5;
    localparam int ID_W    = 16;
    localparam int STAT_W  = 8;
    localparam int TICK_W  = 32;

    localparam logic [TICK_W-1:0] LIFETIME_RST = 32'd1000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_LOOK,
        ST_WRITE,
        ST_PURGE,
        ST_COMMIT,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic             capture;
        logic             clr_acc;
        logic             tick;
        logic             rd_en;
        logic             rd_look;
        logic [IDX_W-1:0] rd_addr;
        logic             write_entry;
        logic             commit;
        logic             load_out;
    } cmd_t;

    typedef struct packed {
        logic is_tick;
        logic out_busy;
    } sts_t;

endpackage

`default_nettype wire

@@ hdl/npt_ctrl.sv @@
// sequencer for the presence table: lookup pass, write, purge pass, result; a tick goes straight to the result
// depends on npt_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module npt_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    output npt_pkg::cmd_t      cmd,
    input  wire npt_pkg::sts_t sts
);
    import npt_pkg::*;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             scan_live;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign scan_live = (cnt_reg < CNT_W'(ENTRIES));

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        cmd.rd_addr = cnt_reg[IDX_W-1:0];
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                cmd.clr_acc = 1'b1;
                cnt_next    = '0;
                if (sts.is_tick)
                begin
                    cmd.tick   = 1'b1;
                    state_next = ST_OUT;
                end
                else
                begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                // the pass ends only after the registered read of the last slot has drained
                if (scan_live)
                begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_look = 1'b1;
                    cnt_next    = cnt_reg + 1'b1;
                end
                else
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                cmd.write_entry = 1'b1;
                cnt_next        = '0;
                state_next      = ST_PURGE;
            end
            ST_PURGE:
            begin
                if (scan_live)
                begin
                    cmd.rd_en = 1'b1;
                    cnt_next  = cnt_reg + 1'b1;
                end
                else
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!sts.out_busy)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `NPT_ASSERT(a_load_when_free, !cmd.load_out || !sts.out_busy,
        "result loaded over a pending one")
    `NPT_ASSERT(a_scan_in_range, !cmd.rd_en || scan_live, "table read past the last slot")
    `NPT_ASSERT_NEXT(a_capture_decodes, cmd.capture, state_reg == ST_DECODE,
        "accepted transfer not decoded")

endmodule

`default_nettype wire

@@ hdl/npt_dpath.sv @@
// datapath: slot memory with valid bits, tick counter, lookup and purge logic,
// aggregates and the result register; depends on npt_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module npt_dpath (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire npt_pkg::cmd_t                cmd,
    output npt_pkg::sts_t                     sts,
    input  wire logic                         mode,
    input  wire logic [npt_pkg::ID_W-1:0]     node_id,
    input  wire logic [npt_pkg::STAT_W-1:0]   node_status,
    input  wire logic                         cfg_we,
    input  wire logic [npt_pkg::TICK_W-1:0]   cfg_wdata,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [npt_pkg::SLOT_W-1:0]        slot,
    output logic [npt_pkg::SLOT_W-1:0]        live_count,
    output logic [npt_pkg::STAT_W-1:0]        status_or,
    output logic [npt_pkg::STAT_W-1:0]        status_and,
    output logic [npt_pkg::STAT_W-1:0]        status_xor
);
    import npt_pkg::*;

    // slot storage, meaningful only where the valid bit is set
    logic [ID_W-1:0]   id_mem    [ENTRIES];
    logic [TICK_W-1:0] stamp_mem [ENTRIES];
    logic [STAT_W-1:0] stat_mem  [ENTRIES];
    logic [ENTRIES-1:0] vld_reg, vld_next;

    logic [TICK_W-1:0] lifetime_reg;
    logic [TICK_W-1:0] now_reg;

    logic              mode_reg;
    logic [ID_W-1:0]   cap_id_reg;
    logic [STAT_W-1:0] cap_stat_reg;

    // registered read port
    logic              rd_go_reg, rd_look_reg, rd_vld_reg;
    logic [IDX_W-1:0]  rd_idx_reg;
    logic [ID_W-1:0]   rd_id_reg;
    logic [TICK_W-1:0] rd_stamp_reg;
    logic [STAT_W-1:0] rd_stat_reg;

    // lookup results
    logic              hit_found_reg, free_found_reg;
    logic [IDX_W-1:0]  hit_idx_reg, free_idx_reg;

    // purge accumulators
    logic [CNT_W-1:0]  acc_cnt_reg;
    logic [STAT_W-1:0] acc_or_reg, acc_and_reg, acc_xor_reg;

    // committed aggregates
    logic [CNT_W-1:0]  live_total_reg;
    logic [STAT_W-1:0] agg_or_reg, agg_and_reg, agg_xor_reg;

    logic [SLOT_W-1:0] slot_reg;

    // result register
    logic              out_valid_reg;
    logic [SLOT_W-1:0] o_slot_reg, o_live_reg;
    logic [STAT_W-1:0] o_or_reg, o_and_reg, o_xor_reg;

    logic              do_write;
    logic [IDX_W-1:0]  wr_idx;
    logic [TICK_W-1:0] age;
    logic              expired;
    logic              purge_item;

    assign do_write = cmd.write_entry && (cap_id_reg != '0)
                      && (live_total_reg < CNT_W'(ENTRIES))
                      && (hit_found_reg || free_found_reg);
    assign wr_idx   = hit_found_reg ? hit_idx_reg : free_idx_reg;

    assign age        = now_reg - rd_stamp_reg;
    assign expired    = (age > lifetime_reg);
    assign purge_item = rd_go_reg && !rd_look_reg && rd_vld_reg;

    always_comb
    begin
        vld_next = vld_reg;
        if (do_write)
        begin
            vld_next[wr_idx] = 1'b1;
        end
        if (purge_item && expired)
        begin
            vld_next[rd_idx_reg] = 1'b0;
        end
    end

    // memory write and read ports
    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            id_mem[wr_idx]    <= cap_id_reg;
            stamp_mem[wr_idx] <= now_reg;
            stat_mem[wr_idx]  <= cap_stat_reg;
        end
        rd_id_reg    <= id_mem[cmd.rd_addr];
        rd_stamp_reg <= stamp_mem[cmd.rd_addr];
        rd_stat_reg  <= stat_mem[cmd.rd_addr];
        rd_vld_reg   <= vld_reg[cmd.rd_addr];
        rd_idx_reg   <= cmd.rd_addr;
    end

    // captured item and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mode_reg     <= mode;
            cap_id_reg   <= node_id;
            cap_stat_reg <= node_status;
        end
        if (cmd.load_out)
        begin
            o_slot_reg <= slot_reg;
            o_live_reg <= SLOT_W'(live_total_reg);
            o_or_reg   <= agg_or_reg;
            o_and_reg  <= agg_and_reg;
            o_xor_reg  <= agg_xor_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg        <= '0;
            lifetime_reg   <= LIFETIME_RST;
            now_reg        <= '0;
            rd_go_reg      <= 1'b0;
            rd_look_reg    <= 1'b0;
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            hit_idx_reg    <= '0;
            free_idx_reg   <= '0;
            acc_cnt_reg    <= '0;
            acc_or_reg     <= '0;
            acc_and_reg    <= '1;
            acc_xor_reg    <= '0;
            live_total_reg <= '0;
            agg_or_reg     <= '0;
            agg_and_reg    <= '0;
            agg_xor_reg    <= '0;
            slot_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            vld_reg     <= vld_next;
            rd_go_reg   <= cmd.rd_en;
            rd_look_reg <= cmd.rd_look;
            if (cfg_we)
            begin
                lifetime_reg <= cfg_wdata;
            end
            if (cmd.tick)
            begin
                now_reg <= now_reg + 1'b1;
            end
            if (cmd.clr_acc)
            begin
                hit_found_reg  <= 1'b0;
                free_found_reg <= 1'b0;
                acc_cnt_reg    <= '0;
                acc_or_reg     <= '0;
                acc_and_reg    <= '1;
                acc_xor_reg    <= '0;
                slot_reg       <= '0;
            end
            // lookup pass keeps the first match and the first empty slot
            if (rd_go_reg && rd_look_reg)
            begin
                if (rd_vld_reg && (rd_id_reg == cap_id_reg) && !hit_found_reg)
                begin
                    hit_found_reg <= 1'b1;
                    hit_idx_reg   <= rd_idx_reg;
                end
                if (!rd_vld_reg && !free_found_reg)
                begin
                    free_found_reg <= 1'b1;
                    free_idx_reg   <= rd_idx_reg;
                end
            end
            if (do_write)
            begin
                slot_reg <= SLOT_W'({1'b0, wr_idx} + 1'b1);
            end
            if (purge_item && !expired)
            begin
                acc_cnt_reg <= acc_cnt_reg + 1'b1;
                acc_or_reg  <= acc_or_reg | rd_stat_reg;
                acc_and_reg <= acc_and_reg & rd_stat_reg;
                acc_xor_reg <= acc_xor_reg ^ rd_stat_reg;
            end
            if (cmd.commit)
            begin
                live_total_reg <= acc_cnt_reg;
                agg_or_reg     <= acc_or_reg;
                agg_and_reg    <= (acc_cnt_reg == '0) ? '0 : acc_and_reg;
                agg_xor_reg    <= acc_xor_reg;
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign sts.is_tick  = !mode_reg;
    assign sts.out_busy = out_valid_reg && !out_ready;

    assign out_valid  = out_valid_reg;
    assign slot       = o_slot_reg;
    assign live_count = o_live_reg;
    assign status_or  = o_or_reg;
    assign status_and = o_and_reg;
    assign status_xor = o_xor_reg;

    `NPT_ASSERT_NEXT(a_count_matches, cmd.commit,
        live_total_reg == $countones(vld_reg),
        "live count differs from valid slots")
    `NPT_ASSERT(a_and_empty, (live_total_reg != '0) || (agg_and_reg == '0),
        "and aggregate nonzero on empty table")
    `NPT_ASSERT(a_one_vld_source, !(do_write && purge_item), "slot write overlaps purge")

endmodule

`default_nettype wire

@@ hdl/node_presence_table_with_aging.sv @@
// node presence table with aging: top level, controller plus datapath
// a tick goes from transfer in through decode to the result; an announce runs a
// lookup pass and a purge pass, each reading one slot per cycle through the
// single registered memory read port; a new item is accepted only once the
// previous result has been loaded, so items never overlap
// reset: asynchronous, clears all valid bits, counters, aggregates, lifetime to 1000
`default_nettype none

module node_presence_table_with_aging (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic                         mode,
    input  wire logic [npt_pkg::ID_W-1:0]     node_id,
    input  wire logic [npt_pkg::STAT_W-1:0]   node_status,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [npt_pkg::SLOT_W-1:0]        slot,
    output logic [npt_pkg::SLOT_W-1:0]        live_count,
    output logic [npt_pkg::STAT_W-1:0]        status_or,
    output logic [npt_pkg::STAT_W-1:0]        status_and,
    output logic [npt_pkg::STAT_W-1:0]        status_xor,
    input  wire logic                         cfg_we,
    input  wire logic [npt_pkg::TICK_W-1:0]   cfg_wdata
);
    import npt_pkg::*;

    cmd_t cmd;
    sts_t sts;

    npt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .sts      (sts)
    );

    npt_dpath u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .mode        (mode),
        .node_id     (node_id),
        .node_status (node_status),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .slot        (slot),
        .live_count  (live_count),
        .status_or   (status_or),
        .status_and  (status_and),
        .status_xor  (status_xor)
    );

endmodule

`default_nettype wire
